// ===== hw/rtl/dtcs_pkg.sv =====
package dtcs_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // Field widths
  localparam int CODE_W  = 24;
  localparam int STAT_W  = 8;
  localparam int LIMIT_W = 12;

  // Response byte accounting
  localparam int HEADER_BYTES = 2;
  localparam int ENTRY_BYTES  = 4;
  localparam int USED_W       = $clog2(HEADER_BYTES + ENTRY_BYTES * TABLE_DEPTH + 1);
  localparam int CMP_W        = ((USED_W > LIMIT_W) ? USED_W : LIMIT_W) + 1;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET     = 12'hFFF;
  localparam logic [CODE_W-1:0]  CLEAR_ALL_GROUP = 24'hFFFFFF;

  // Operation codes
  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_REPORT = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  // Result item kinds
  typedef enum logic [1:0] {
    KIND_ACK    = 2'd0,
    KIND_HEADER = 2'd1,
    KIND_ENTRY  = 2'd2
  } kind_t;

  // Outcome codes
  typedef enum logic [1:0] {
    OC_OK    = 2'd0,
    OC_RANGE = 2'd1,
    OC_FULL  = 2'd2
  } outcome_t;

  // One table entry as it travels along the chain
  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [STAT_W-1:0] status;
  } entry_t;

  // One result item
  typedef struct packed {
    kind_t             kind;
    outcome_t          outcome;
    logic [STAT_W-1:0] avail;
    logic [CODE_W-1:0] code;
    logic [STAT_W-1:0] status;
    logic              last;
  } out_item_t;

  function automatic out_item_t make_ack(outcome_t oc);
    out_item_t r;
    r.kind    = KIND_ACK;
    r.outcome = oc;
    r.avail   = '0;
    r.code    = '0;
    r.status  = '0;
    r.last    = 1'b1;
    return r;
  endfunction

endpackage

// ===== hw/rtl/dtcs_cell.sv =====
module dtcs_cell
  import dtcs_pkg::*;
(
  input  logic   clk,
  input  logic   shift_en,
  input  entry_t d_in,
  output entry_t q
);

  entry_t entry_r;

  // Hold one entry; pass it to the neighbor while the ring rotates
  always_ff @(posedge clk) begin
    if (shift_en) begin
      entry_r <= d_in;
    end
  end

  assign q = entry_r;

endmodule

// ===== hw/rtl/diagnostic_trouble_code_store_unit.sv =====
// Diagnostic trouble code store.
// Input channel: an item (in_operation, in_dtc_code, in_status_bits,
// in_status_mask, in_group_code) is taken on a clock edge with start high
// and busy low. Results come out at most one per cycle with out_valid high for
// exactly one cycle; out_last marks the final result of an item.
// Configuration: cfg_wr_en writes cfg_wr_data into the response byte limit.
// Entries sit in a ring of TABLE_DEPTH cells that rotates once per add or
// report, so each item walks the whole ring one cell per cycle.
// Operation handling:
//   clear and unused operation: the ack is registered and busy stays low,
//     so a new item can be taken without waiting for the ack.
//   add: busy while the ring rotates; the ack follows the last cell of the scan.
//   report: header and entries come out during the scan and after it; busy
//     through the scan and the done state. Each item is held back until
//     the next matching entry or the end of the scan so that out_last can be
//     set on the final one.
// Reset clears the entry count, the status summary and sets the limit to
// 4095; entry contents are not cleared. Results cannot be stalled.
module diagnostic_trouble_code_store_unit
  import dtcs_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_operation,
  input  logic [CODE_W-1:0]  in_dtc_code,
  input  logic [STAT_W-1:0]  in_status_bits,
  input  logic [STAT_W-1:0]  in_status_mask,
  input  logic [CODE_W-1:0]  in_group_code,
  input  logic               cfg_wr_en,
  input  logic [LIMIT_W-1:0] cfg_wr_data,
  output logic               out_valid,
  output logic [1:0]         out_item_kind,
  output logic [1:0]         out_outcome,
  output logic [STAT_W-1:0]  out_availability_mask,
  output logic [CODE_W-1:0]  out_entry_code,
  output logic [STAT_W-1:0]  out_entry_status,
  output logic               out_last
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t             state_r, state_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [STAT_W-1:0]  avail_r, avail_nxt;
  logic [LIMIT_W-1:0] limit_r;
  op_t                op_r, op_nxt;
  logic [CODE_W-1:0]  code_r, code_nxt;
  logic [STAT_W-1:0]  bits_r, bits_nxt;
  logic [STAT_W-1:0]  mask_r, mask_nxt;
  logic               found_r, found_nxt;
  logic               stop_r, stop_nxt;
  logic [USED_W-1:0]  used_r, used_nxt;
  out_item_t          pend_r, pend_nxt;
  out_item_t          out_r, out_nxt;
  logic               out_valid_r, out_valid_nxt;

  entry_t             cell_q [TABLE_DEPTH];
  entry_t             feed;
  entry_t             head;
  logic               shift_en;
  logic               in_use;
  logic               at_tail;
  logic               last_idx;
  out_item_t          ent_item;
  logic [CMP_W-1:0]   need_bytes;

  // Ring of cells: cell 0 is the head, the controller feeds the tail
  assign shift_en = (state_r == ST_SCAN);

  for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
    entry_t d_k;
    if (k == TABLE_DEPTH - 1) begin : g_tail
      assign d_k = feed;
    end else begin : g_mid
      assign d_k = cell_q[k+1];
    end
    dtcs_cell u_cell (
      .clk      (clk),
      .shift_en (shift_en),
      .d_in     (d_k),
      .q        (cell_q[k])
    );
  end

  assign head     = cell_q[0];
  assign in_use   = (CNT_W'(idx_r) < count_r);
  assign at_tail  = (CNT_W'(idx_r) == count_r);
  assign last_idx = (idx_r == IDX_W'(TABLE_DEPTH - 1));
  assign need_bytes = CMP_W'(used_r) + CMP_W'(ENTRY_BYTES);

  always_comb begin
    ent_item.kind    = KIND_ENTRY;
    ent_item.outcome = OC_OK;
    ent_item.avail   = '0;
    ent_item.code    = head.code;
    ent_item.status  = head.status;
    ent_item.last    = 1'b0;
  end

  // Controller: accepts items, walks the ring, forms result items
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    count_nxt     = count_r;
    avail_nxt     = avail_r;
    op_nxt        = op_r;
    code_nxt      = code_r;
    bits_nxt      = bits_r;
    mask_nxt      = mask_r;
    found_nxt     = found_r;
    stop_nxt      = stop_r;
    used_nxt      = used_r;
    pend_nxt      = pend_r;
    out_nxt       = out_r;
    out_valid_nxt = 1'b0;
    feed          = head;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          op_nxt    = op_t'(in_operation);
          code_nxt  = in_dtc_code;
          bits_nxt  = in_status_bits;
          mask_nxt  = in_status_mask;
          idx_nxt   = '0;
          found_nxt = 1'b0;
          stop_nxt  = 1'b0;
          used_nxt  = USED_W'(HEADER_BYTES);
          case (op_t'(in_operation))
            OP_ADD: begin
              state_nxt = ST_SCAN;
            end
            OP_REPORT: begin
              state_nxt      = ST_SCAN;
              pend_nxt       = make_ack(OC_OK);
              pend_nxt.kind  = KIND_HEADER;
              pend_nxt.avail = avail_r;
              pend_nxt.last  = 1'b0;
            end
            OP_CLEAR: begin
              out_valid_nxt = 1'b1;
              if (in_group_code == CLEAR_ALL_GROUP) begin
                count_nxt = '0;
                avail_nxt = '0;
                out_nxt   = make_ack(OC_OK);
              end else begin
                out_nxt   = make_ack(OC_RANGE);
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
              out_nxt       = make_ack(OC_OK);
            end
          endcase
        end
      end

      ST_SCAN: begin
        idx_nxt = idx_r + IDX_W'(1);
        if (op_r == OP_ADD) begin
          // Merge on match, append at the first free slot
          if (in_use && head.code == code_r) begin
            feed.status = head.status | bits_r;
            found_nxt   = 1'b1;
            avail_nxt   = avail_r | bits_r;
          end else if (at_tail && !found_r) begin
            feed.code   = code_r;
            feed.status = bits_r;
            found_nxt   = 1'b1;
            count_nxt   = count_r + CNT_W'(1);
            avail_nxt   = avail_r | bits_r;
          end
          if (last_idx) begin
            state_nxt     = ST_IDLE;
            out_valid_nxt = 1'b1;
            out_nxt       = make_ack(found_nxt ? OC_OK : OC_FULL);
          end
        end else begin
          // Report: release the held item when a new entry qualifies
          if (in_use && (head.status & mask_r) != '0 && !stop_r) begin
            if (need_bytes > CMP_W'(limit_r)) begin
              stop_nxt = 1'b1;
            end else begin
              used_nxt      = need_bytes[USED_W-1:0];
              out_valid_nxt = 1'b1;
              out_nxt       = pend_r;
              pend_nxt      = ent_item;
            end
          end
          if (last_idx) begin
            state_nxt = ST_DONE;
          end
        end
      end

      ST_DONE: begin
        out_valid_nxt = 1'b1;
        out_nxt       = pend_r;
        out_nxt.last  = 1'b1;
        state_nxt     = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      avail_r     <= '0;
      limit_r     <= LIMIT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      avail_r     <= avail_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
      end
    end
  end

  // Item context and result payload
  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    op_r    <= op_nxt;
    code_r  <= code_nxt;
    bits_r  <= bits_nxt;
    mask_r  <= mask_nxt;
    found_r <= found_nxt;
    stop_r  <= stop_nxt;
    used_r  <= used_nxt;
    pend_r  <= pend_nxt;
    out_r   <= out_nxt;
  end

  assign busy                  = (state_r != ST_IDLE);
  assign out_valid             = out_valid_r;
  assign out_item_kind         = out_r.kind;
  assign out_outcome           = out_r.outcome;
  assign out_availability_mask = out_r.avail;
  assign out_entry_code        = out_r.code;
  assign out_entry_status      = out_r.status;
  assign out_last              = out_r.last;

endmodule

// ===== sim/tb_diagnostic_trouble_code_store_unit.sv =====
`timescale 1ns / 1ps

module tb_diagnostic_trouble_code_store_unit;
  import dtcs_pkg::*;

  localparam int SETTLE_CYCLES = TABLE_DEPTH + 4;
  localparam int MAX_PRINTS    = 40;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         in_operation = OP_NONE;
  logic [CODE_W-1:0]  in_dtc_code = '0;
  logic [STAT_W-1:0]  in_status_bits = '0;
  logic [STAT_W-1:0]  in_status_mask = '0;
  logic [CODE_W-1:0]  in_group_code = '0;
  logic               cfg_wr_en = 1'b0;
  logic [LIMIT_W-1:0] cfg_wr_data = '0;
  logic               out_valid;
  logic [1:0]         out_item_kind;
  logic [1:0]         out_outcome;
  logic [STAT_W-1:0]  out_availability_mask;
  logic [CODE_W-1:0]  out_entry_code;
  logic [STAT_W-1:0]  out_entry_status;
  logic               out_last;

  // Shadow copy of the code table and the byte limit
  logic [CODE_W-1:0]  shadow_codes [TABLE_DEPTH];
  logic [STAT_W-1:0]  shadow_status [TABLE_DEPTH];
  int                 shadow_count;
  logic [LIMIT_W-1:0] shadow_limit;

  out_item_t          pending_results [$];
  out_item_t          want;
  int                 error_count = 0;
  logic [CODE_W-1:0]  code_pool [24];

  diagnostic_trouble_code_store_unit i_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .start                 (start),
    .busy                  (busy),
    .in_operation          (in_operation),
    .in_dtc_code           (in_dtc_code),
    .in_status_bits        (in_status_bits),
    .in_status_mask        (in_status_mask),
    .in_group_code         (in_group_code),
    .cfg_wr_en             (cfg_wr_en),
    .cfg_wr_data           (cfg_wr_data),
    .out_valid             (out_valid),
    .out_item_kind         (out_item_kind),
    .out_outcome           (out_outcome),
    .out_availability_mask (out_availability_mask),
    .out_entry_code        (out_entry_code),
    .out_entry_status      (out_entry_status),
    .out_last              (out_last)
  );

  always #10 clk = ~clk;

  function automatic out_item_t ack_item(outcome_t oc);
    out_item_t r;
    r         = '0;
    r.kind    = KIND_ACK;
    r.outcome = oc;
    r.last    = 1'b1;
    return r;
  endfunction

  // Apply one accepted item to the shadow table, queue the items it yields
  task automatic table_apply(input op_t op, input logic [CODE_W-1:0] code,
                             input logic [STAT_W-1:0] bits,
                             input logic [STAT_W-1:0] mask,
                             input logic [CODE_W-1:0] group);
    out_item_t         listing [$];
    out_item_t         r;
    logic [STAT_W-1:0] summary;
    int                used;
    int                hit;
    hit = -1;
    case (op)
      OP_ADD: begin
        for (int i = 0; i < shadow_count; i++)
          if (hit < 0 && shadow_codes[i] == code) hit = i;
        if (hit >= 0) begin
          shadow_status[hit] = shadow_status[hit] | bits;
          pending_results.push_back(ack_item(OC_OK));
        end else if (shadow_count < TABLE_DEPTH) begin
          shadow_codes[shadow_count]  = code;
          shadow_status[shadow_count] = bits;
          shadow_count++;
          pending_results.push_back(ack_item(OC_OK));
        end else begin
          pending_results.push_back(ack_item(OC_FULL));
        end
      end
      OP_CLEAR: begin
        if (group == CLEAR_ALL_GROUP) begin
          shadow_count = 0;
          pending_results.push_back(ack_item(OC_OK));
        end else begin
          pending_results.push_back(ack_item(OC_RANGE));
        end
      end
      OP_REPORT: begin
        summary = '0;
        for (int i = 0; i < shadow_count; i++) summary |= shadow_status[i];
        r       = '0;
        r.kind  = KIND_HEADER;
        r.avail = summary;
        listing.push_back(r);
        used = HEADER_BYTES;
        for (int i = 0; i < shadow_count; i++) begin
          if ((shadow_status[i] & mask) != '0) begin
            if (used + ENTRY_BYTES > int'(shadow_limit)) break;
            used += ENTRY_BYTES;
            r        = '0;
            r.kind   = KIND_ENTRY;
            r.code   = shadow_codes[i];
            r.status = shadow_status[i];
            listing.push_back(r);
          end
        end
        // only the final item of the response carries last
        r      = listing[listing.size()-1];
        r.last = 1'b1;
        listing[listing.size()-1] = r;
        foreach (listing[k]) pending_results.push_back(listing[k]);
      end
      default: pending_results.push_back(ack_item(OC_OK));
    endcase
  endtask

  // Drive one item, hold it until taken, then idle for gap cycles
  task automatic send_item(input op_t op, input logic [CODE_W-1:0] code,
                           input logic [STAT_W-1:0] bits,
                           input logic [STAT_W-1:0] mask,
                           input logic [CODE_W-1:0] group, input int gap);
    bit taken;
    taken          = 1'b0;
    in_operation   <= op;
    in_dtc_code    <= code;
    in_status_bits <= bits;
    in_status_mask <= mask;
    in_group_code  <= group;
    start          <= 1'b1;
    while (!taken) begin
      @(negedge clk);
      taken = (busy === 1'b0);
      @(posedge clk);
    end
    table_apply(op, code, bits, mask, group);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop sending and wait until every queued item has come back
  task automatic drain_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_limit(input logic [LIMIT_W-1:0] value);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en    <= 1'b0;
    shadow_limit = value;
  endtask

  // Mostly back to back, sometimes a few cycles, rarely a long pause
  function automatic int idle_cycles();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Empty table, group checks, merge, masks, unused operation
  task automatic test_basic_ops();
    send_item(OP_REPORT, 24'h0, 8'h0, 8'hFF, 24'h0, idle_cycles());
    send_item(OP_CLEAR, 24'h0, 8'h0, 8'h0, 24'h000000, idle_cycles());
    send_item(OP_CLEAR, 24'h0, 8'h0, 8'h0, 24'hFFFFFE, idle_cycles());
    send_item(OP_ADD, 24'h000000, 8'h00, 8'h0, 24'h0, idle_cycles());
    send_item(OP_ADD, 24'hFFFFFF, 8'hFF, 8'h0, 24'h0, idle_cycles());
    send_item(OP_ADD, 24'h000000, 8'h5A, 8'h0, 24'h0, idle_cycles());
    send_item(OP_ADD, 24'h123456, 8'hA5, 8'h0, 24'h0, idle_cycles());
    send_item(OP_REPORT, 24'h0, 8'h0, 8'h00, 24'h0, idle_cycles());
    send_item(OP_REPORT, 24'h0, 8'h0, 8'h01, 24'h0, idle_cycles());
    send_item(OP_NONE, 24'hFFFFFF, 8'hFF, 8'hFF, 24'hFFFFFF, 0);
    send_item(OP_REPORT, 24'h0, 8'h0, 8'hFF, 24'h0, idle_cycles());
    send_item(OP_CLEAR, 24'h0, 8'h0, 8'h0, CLEAR_ALL_GROUP, idle_cycles());
    send_item(OP_REPORT, 24'h0, 8'h0, 8'hFF, 24'h0, idle_cycles());
  endtask

  // Fill every slot, drop on overflow, merge while full, full listing
  task automatic test_table_full();
    for (int i = 0; i < TABLE_DEPTH; i++)
      send_item(OP_ADD, {8'hA0 + 8'(i), 16'h5A5A ^ 16'(i)}, 8'(1 << (i % 8)), 8'h0,
                24'h0, (i < 8) ? 0 : idle_cycles());
    send_item(OP_ADD, 24'hC0FFEE, 8'h11, 8'h0, 24'h0, idle_cycles());
    send_item(OP_ADD, {8'hA3, 16'h5A59}, 8'h80, 8'h0, 24'h0, idle_cycles());
    send_item(OP_REPORT, 24'h0, 8'h0, 8'hFF, 24'h0, 0);
    send_item(OP_REPORT, 24'h0, 8'h0, 8'h01, 24'h0, idle_cycles());
    send_item(OP_CLEAR, 24'h0, 8'h0, 8'h0, CLEAR_ALL_GROUP, idle_cycles());
  endtask

  // Byte budget edges: below the header, exactly one and two entries
  task automatic test_response_limit();
    logic [STAT_W-1:0] stats [5];
    logic [LIMIT_W-1:0] limits [9];
    stats  = '{8'h01, 8'h02, 8'h04, 8'h80, 8'h03};
    limits = '{12'd0, 12'd1, 12'd2, 12'd5, 12'd6, 12'd9, 12'd10, 12'd14, 12'd4095};
    foreach (stats[i])
      send_item(OP_ADD, 24'h400000 + 24'(i), stats[i], 8'h0, 24'h0, idle_cycles());
    foreach (limits[j]) begin
      set_limit(limits[j]);
      send_item(OP_REPORT, 24'h0, 8'h0, (j % 2 == 0) ? 8'hFF : 8'h03, 24'h0, 0);
    end
  endtask

  // Random traffic in phases, each phase under its own byte limit
  task automatic test_random_traffic();
    logic [LIMIT_W-1:0] phase_limit [6];
    logic [CODE_W-1:0]  code;
    logic [STAT_W-1:0]  bits;
    logic [STAT_W-1:0]  mask;
    logic [CODE_W-1:0]  group;
    op_t                op;
    int                 p;
    int                 gap;
    bit                 quiet;
    phase_limit = '{12'd4095, 12'd0, 12'd6, 12'd18, 12'($urandom_range(0, 80)),
                    12'($urandom_range(0, 4095))};
    foreach (code_pool[i]) code_pool[i] = 24'($urandom);
    for (int ph = 0; ph < 6; ph++) begin
      set_limit(phase_limit[ph]);
      for (int n = 0; n < 60; n++) begin
        // stretches without any idling
        quiet = (ph % 2 == 1) && (n < 30);
        code  = ($urandom_range(0, 9) < 7) ? code_pool[$urandom_range(0, 23)]
                                           : 24'($urandom);
        bits  = ($urandom_range(0, 9) == 0) ? 8'h00 : 8'($urandom);
        mask  = ($urandom_range(0, 4) == 0) ? 8'hFF : 8'($urandom);
        group = 24'($urandom);
        p     = $urandom_range(0, 99);
        if (p < 50) op = OP_ADD;
        else if (p < 75) op = OP_REPORT;
        else if (p < 82) begin
          op    = OP_CLEAR;
          group = CLEAR_ALL_GROUP;
        end else if (p < 89) op = OP_CLEAR;
        else op = OP_NONE;
        if ($urandom_range(0, 39) == 0) drain_results();
        gap = quiet ? 0 : idle_cycles();
        send_item(op, code, bits, mask, group, gap);
      end
    end
  endtask

  task automatic note_mismatch(input string field, input longint unsigned exp_v,
                               input longint unsigned act_v);
    error_count++;
    if (error_count <= MAX_PRINTS)
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, exp_v, act_v);
  endtask

  // Compare each result item with the oldest expectation
  always @(negedge clk) begin
    if (rst_n === 1'b1 && out_valid !== 1'b0) begin
      if (pending_results.size() == 0) begin
        error_count++;
        if (error_count <= MAX_PRINTS)
          $display("%0t: unexpected item, expected none, actual kind %0h code %0h",
                   $time, out_item_kind, out_entry_code);
      end else begin
        want = pending_results.pop_front();
        if (out_item_kind !== want.kind) note_mismatch("kind", want.kind, out_item_kind);
        if (out_outcome !== want.outcome)
          note_mismatch("outcome", want.outcome, out_outcome);
        if (out_availability_mask !== want.avail)
          note_mismatch("availability", want.avail, out_availability_mask);
        if (out_entry_code !== want.code) note_mismatch("code", want.code, out_entry_code);
        if (out_entry_status !== want.status)
          note_mismatch("status", want.status, out_entry_status);
        if (out_last !== want.last) note_mismatch("last", want.last, out_last);
      end
    end
  end

  initial begin
    shadow_count = 0;
    shadow_limit = LIMIT_RESET;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_basic_ops();
    test_table_full();
    test_response_limit();
    test_random_traffic();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Run time guard
  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
